### rtl/core/knss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knss_pkg
// Shared types and constants of the sorted k-nearest selection core.
// ----------------------------------------------------------------------------
package knss_pkg;

  // Field widths
  localparam int DIST_W     = 32;
  localparam int ID_W       = 16;
  localparam int CNT_W      = 5;
  localparam int K_W        = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Command codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_START = 2'd0;
  localparam cmd_t CMD_OFFER = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_K_LIMIT    = 1'd0;
  localparam cfg_idx_t CFG_INIT_RANGE = 1'd1;

  localparam logic [K_W-1:0] K_LIMIT_RST = 5'd16;

  typedef struct packed {
    cmd_t              cmd;
    logic [DIST_W-1:0] distance_sq;
    logic [ID_W-1:0]   cand_id;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] range_out;
    logic              entry_valid;
    logic [DIST_W-1:0] entry_distance;
    logic [ID_W-1:0]   entry_id;
    logic              last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic offer;
    logic read_start;
    logic read_step;
    logic load_report;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic read_last;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/core/k_nearest_sorted_select_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_nearest_sorted_select_core
// Keeps the k nearest candidates sorted by squared distance; start, offer
// and read-out requests, with a configuration write port.
// ----------------------------------------------------------------------------
// Start and offer: as the request is taken, start clears the held count and
//   offer runs the compare-and-shift over the list cells; a report state in
//   the sequencer then loads the result, and no new request is taken before
//   it loads. A stalled output holds the report and keeps the input closed.
// Read-out: one result per held entry (one if empty), one per cycle while the
//   output register is free; next request taken after the last result loads.
// Reset (synchronous, rst_n low) clears held count and handshake flags and
//   sets k_limit to 16 and initial_range to all ones; list cells are not
//   cleared. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module k_nearest_sorted_select_core
  import knss_pkg::*;
#(
  parameter int LIST_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire cfg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  knss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  knss_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_data  (out_data)
  );

  // At most one datapath step per cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(dp_cmd))
    else $error("more than one datapath step in a cycle");

  // A result is loaded only into a free output register
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.load_report || dp_cmd.read_step) |-> (!out_valid || out_ready))
    else $error("result overwrote a pending result");

  // Start and offer close the input until their report is loaded
  a_report_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.offer || dp_cmd.clear) |=> !in_ready)
    else $error("request taken before report");

  // The last read-out step reopens the input
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.read_step && dp_stat.read_last) |=> in_ready)
    else $error("input not reopened after read-out");

endmodule
`default_nettype wire

### rtl/core/knss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knss_ctrl
// Sequencer: takes one request at a time, steers the datapath through
// clear, offer, report and read-out steps, and owns the handshake flags.
// ----------------------------------------------------------------------------
module knss_ctrl
  import knss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire cmd_t     in_cmd,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       dp_cmd,
  input  wire dp_stat_t dp_stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPORT,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // Output register can take a new result
  assign slot_free = !out_valid_r || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    dp_cmd        = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          case (in_cmd)
            CMD_START: begin
              dp_cmd.clear = 1'b1;
              state_nxt    = S_REPORT;
            end
            CMD_OFFER: begin
              dp_cmd.offer = 1'b1;
              state_nxt    = S_REPORT;
            end
            CMD_READ: begin
              dp_cmd.read_start = 1'b1;
              state_nxt         = S_READ;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          dp_cmd.load_report = 1'b1;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free) begin
          dp_cmd.read_step = 1'b1;
          out_valid_nxt    = 1'b1;
          if (dp_stat.read_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  // Hold state and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/core/knss_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knss_dp
// Datapath: a row of list cells with a parallel compare-and-shift for
// insertion and a rotate path for read-out, the configuration registers,
// the held count and the result register.
// ----------------------------------------------------------------------------
module knss_dp
  import knss_pkg::*;
#(
  parameter int LIST_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire cfg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire dp_cmd_t               dp_cmd,
  output dp_stat_t                   dp_stat,
  output out_item_t                  out_data
);

  localparam int HW = $clog2(LIST_DEPTH + 1);
  localparam int CW = (HW > K_W) ? HW : K_W;

  // List cells (contents undefined until written)
  logic [DIST_W-1:0] kd_r   [LIST_DEPTH];
  logic [DIST_W-1:0] kd_nxt [LIST_DEPTH];
  logic [ID_W-1:0]   ki_r   [LIST_DEPTH];
  logic [ID_W-1:0]   ki_nxt [LIST_DEPTH];

  logic [HW-1:0]     held_r, held_nxt;
  logic [HW-1:0]     rd_idx_r;
  logic              acc_r;
  logic [K_W-1:0]    k_r;
  logic [DIST_W-1:0] init_r;
  logic [DIST_W-1:0] rng_cap_r;
  out_item_t         out_r;

  logic [LIST_DEPTH-1:0] lt, in_held, tail_oh, in_ext;
  logic [CW-1:0]         eff_k;
  logic                  full;
  logic                  lt_tail;
  logic                  acc_now;
  logic [DIST_W-1:0]     tail_dist;
  logic [DIST_W-1:0]     range_now;
  logic                  rd_last;
  logic                  list_empty;

  // Clamp the limit to 1..LIST_DEPTH and test for a full list
  always_comb begin
    if (k_r == '0) begin
      eff_k = CW'(1);
    end else if (CW'(k_r) > CW'(LIST_DEPTH)) begin
      eff_k = CW'(LIST_DEPTH);
    end else begin
      eff_k = CW'(k_r);
    end
    full = CW'(held_r) >= eff_k;
  end

  // Per-cell compare and position flags
  always_comb begin
    tail_dist = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      lt[i]      = in_data.distance_sq < kd_r[i];
      in_held[i] = HW'(i) < held_r;
      tail_oh[i] = HW'(i + 1) == held_r;
      in_ext[i]  = full ? in_held[i] : (HW'(i) <= held_r);
      tail_dist  = tail_dist | (tail_oh[i] ? kd_r[i] : '0);
    end
  end

  // Reject when full unless strictly closer than the farthest kept entry
  assign lt_tail    = |(lt & tail_oh);
  assign acc_now    = full ? lt_tail : 1'b1;
  assign range_now  = full ? tail_dist : init_r;
  assign list_empty = (held_r == '0);
  assign rd_last    = list_empty || ((HW + 1)'(rd_idx_r) + 1'b1 == (HW + 1)'(held_r));

  assign dp_stat.read_last = rd_last;

  // Insert by shifting, or rotate the held entries during read-out
  always_comb begin
    int pi;
    int ni;
    logic sh;
    pi = 0;
    ni = 0;
    sh = 1'b0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      kd_nxt[i] = kd_r[i];
      ki_nxt[i] = ki_r[i];
    end
    if (dp_cmd.offer && acc_now) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        pi = (i == 0) ? 0 : i - 1;
        sh = (i != 0) && in_held[pi] && lt[pi];
        if (in_ext[i]) begin
          if (sh) begin
            kd_nxt[i] = kd_r[pi];
            ki_nxt[i] = ki_r[pi];
          end else if (in_held[i] ? lt[i] : 1'b1) begin
            kd_nxt[i] = in_data.distance_sq;
            ki_nxt[i] = in_data.cand_id;
          end
        end
      end
    end else if (dp_cmd.read_step) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        ni = (i == LIST_DEPTH - 1) ? i : i + 1;
        if (in_held[i]) begin
          if (tail_oh[i]) begin
            kd_nxt[i] = kd_r[0];
            ki_nxt[i] = ki_r[0];
          end else begin
            kd_nxt[i] = kd_r[ni];
            ki_nxt[i] = ki_r[ni];
          end
        end
      end
    end
  end

  // Clear or advance the held count
  always_comb begin
    held_nxt = held_r;
    if (dp_cmd.clear) begin
      held_nxt = '0;
    end else if (dp_cmd.offer && acc_now && !full) begin
      held_nxt = held_r + 1'b1;
    end
  end

  // Hold list cells
  always_ff @(posedge clk) begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      kd_r[i] <= kd_nxt[i];
      ki_r[i] <= ki_nxt[i];
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      acc_r  <= 1'b0;
      k_r    <= K_LIMIT_RST;
      init_r <= '1;
    end else begin
      held_r <= held_nxt;
      if (dp_cmd.clear) begin
        acc_r <= 1'b0;
      end else if (dp_cmd.offer) begin
        acc_r <= acc_now;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_K_LIMIT:    k_r    <= cfg_data[K_W-1:0];
          CFG_INIT_RANGE: init_r <= cfg_data[DIST_W-1:0];
          default:        k_r    <= k_r;
        endcase
      end
    end
  end

  // Read-out rank counter and captured range
  always_ff @(posedge clk) begin
    if (dp_cmd.read_start) begin
      rd_idx_r  <= '0;
      rng_cap_r <= range_now;
    end else if (dp_cmd.read_step) begin
      rd_idx_r  <= rd_idx_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (dp_cmd.load_report) begin
      out_r.accepted       <= acc_r;
      out_r.count          <= CNT_W'(held_r);
      out_r.range_out      <= range_now;
      out_r.entry_valid    <= 1'b0;
      out_r.entry_distance <= '0;
      out_r.entry_id       <= '0;
      out_r.last           <= 1'b0;
    end else if (dp_cmd.read_step) begin
      out_r.accepted       <= 1'b0;
      out_r.count          <= CNT_W'(held_r);
      out_r.range_out      <= rng_cap_r;
      out_r.entry_valid    <= !list_empty;
      out_r.entry_distance <= list_empty ? '0 : kd_r[0];
      out_r.entry_id       <= list_empty ? '0 : ki_r[0];
      out_r.last           <= rd_last;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire
